// ===== design/tbhs_pkg.sv =====
package tbhs_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CALIB_COUNT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_WEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GYRO_GAIN    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEAD_BAND    = 2'd3;

  localparam logic [1:0] ACT_CAL  = 2'd0;
  localparam logic [1:0] ACT_POS  = 2'd1;
  localparam logic [1:0] ACT_NEG  = 2'd2;
  localparam logic [1:0] ACT_HOLD = 2'd3;

  localparam logic [3:0] COIL_HOLD = 4'd8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_CORD  = 7'b0000100,
    S_GYRO  = 7'b0001000,
    S_MIX   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] coil_of(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0: c = 4'd1;
      3'd1: c = 4'd3;
      3'd2: c = 4'd2;
      3'd3: c = 4'd6;
      3'd4: c = 4'd4;
      3'd5: c = 4'd12;
      3'd6: c = 4'd8;
      3'd7: c = 4'd9;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tilt_balance_half_step_drive_top.sv =====
// Channel   Direction  Handshake            Payload
// s_axis    in         tvalid / tready      tdata: accel_x, accel_z, gyro_x, gyro_y
// m_axis    out        tvalid / tready      tdata: tilt, action, coils; tuser: calibrating
// cfg       in         cfg_valid / ready    cfg_index, cfg_data
//
// A calibration request goes straight to the output stage, and the one that completes
// calibration first passes through the bit-serial offset divider.
// A tilt request passes through the iterative CORDIC unit, then the gyro, mix and finish steps.
// Reset is asynchronous and restores the register defaults and calibration state.
// A stalled result waits in the output register while the next request is accepted.
module tilt_balance_half_step_drive_top import tbhs_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 16,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // accel_x, accel_z, gyro_x, gyro_y, zero padding
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tilt_angle[16:0], action[18:17], motor_one_coils[22:19], motor_two_coils[26:23]
  output logic [31:0]                           m_axis_tdata_o,
  // calibrating
  output logic                                  m_axis_tuser_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]                    cfg_index_i,
  input  logic [16:0]                           cfg_data_i
);

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned XW   = SB + 3;
  localparam int unsigned ZW   = 26;
  localparam int unsigned RSW  = SB + 10;
  localparam int unsigned DCW  = $clog2(RSW + 1);
  localparam int unsigned PW   = SB + 18;
  localparam int unsigned LW   = ((SB + 4 > 17) ? SB + 4 : 17) + 1;
  localparam int unsigned SW   = LW + 19;
  localparam logic [4:0]  ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

  state_e state_q, state_d;

  logic [9:0]  calib_count_q;
  logic [16:0] accel_weight_q;
  logic [15:0] gyro_gain_q;
  logic [15:0] dead_band_q;

  logic                  calib_done_q;
  logic [9:0]            acc_cnt_q;
  logic signed [RSW-1:0] rate_sum_q;
  logic signed [SB-1:0]  rate_off_q;
  logic signed [16:0]    filt_q;
  logic [2:0]            ph1_q, ph2_q;

  logic [RSW-1:0]        dvd_q;
  logic [10:0]           rem_q;
  logic                  neg_q;
  logic [DCW-1:0]        dcnt_q;

  logic signed [SB-1:0]  gy_q;
  logic signed [XW-1:0]  cx_q, cy_q;
  logic signed [ZW-1:0]  cz_q;
  logic                  zero_q;
  logic [4:0]            it_q;
  logic signed [16:0]    acc_q;

  logic signed [PW-1:0]  gprod_q;
  logic signed [34:0]    p1_q;
  logic signed [LW+17:0] p2_q;

  logic                  res_cal_q;
  logic [26:0]           res_q;
  logic                  out_valid_q;
  logic                  out_cal_q;
  logic [26:0]           out_q;

  logic signed [SB-1:0]  in_ax, in_az, in_gx, in_gy;
  logic                  in_fire;

  assign in_ax = s_axis_tdata_i[SB-1:0];
  assign in_az = s_axis_tdata_i[2*SB-1:SB];
  assign in_gx = s_axis_tdata_i[3*SB-1:2*SB];
  assign in_gy = s_axis_tdata_i[4*SB-1:3*SB];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_cal_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

  logic [9:0]            target;
  logic [9:0]            cnt_inc;
  logic signed [RSW-1:0] sum_inc;
  logic [RSW-1:0]        sum_abs;
  assign target  = (calib_count_q == 10'd0) ? 10'd1 : calib_count_q;
  assign cnt_inc = acc_cnt_q + 10'd1;
  assign sum_inc = rate_sum_q + RSW'(in_gy);
  assign sum_abs = sum_inc[RSW-1] ? RSW'(-sum_inc) : RSW'(sum_inc);

  logic [10:0] trial;
  logic        take;
  assign trial = {rem_q[9:0], dvd_q[RSW-1]};
  assign take  = trial >= {1'b0, acc_cnt_q};

  logic signed [XW-1:0] sx0, sy0, cdx, cdy;
  logic signed [ZW-1:0] sz0, catan, zr;
  always_comb begin
    sx0 = XW'(in_az);
    sy0 = XW'(in_ax);
    sz0 = '0;
    if (in_az < 0) begin
      if (in_ax >= 0) begin
        sx0 = XW'(in_ax);
        sy0 = -XW'(in_az);
        sz0 = ZW'(90 * 65536);
      end else begin
        sx0 = -XW'(in_ax);
        sy0 = XW'(in_az);
        sz0 = -ZW'(90 * 65536);
      end
    end
  end
  assign cdx   = cy_q >>> it_q;
  assign cdy   = cx_q >>> it_q;
  assign catan = ZW'({1'b0, atan_q16(it_q)});
  assign zr    = (cz_q + ZW'(128)) >>> 8;

  logic signed [16:0] cord_res;
  always_comb begin
    if (zero_q) begin
      cord_res = '0;
    end else if (zr > ZW'(46080)) begin
      cord_res = 17'sd46080;
    end else if (zr < -ZW'(46080)) begin
      cord_res = -17'sd46080;
    end else begin
      cord_res = zr[16:0];
    end
  end

  logic signed [SB:0]   gdiff;
  logic signed [PW-1:0] gprod;
  assign gdiff = (SB + 1)'(gy_q) - (SB + 1)'(rate_off_q);
  assign gprod = PW'(gdiff) * PW'($signed({1'b0, gyro_gain_q}));

  logic signed [LW-1:0] gstep, ls;
  logic signed [17:0]   w, wc;
  assign gstep = -LW'((gprod_q + PW'(32768)) >>> 16);
  assign ls    = LW'(filt_q) + gstep;
  assign w     = (accel_weight_q > 17'd65536) ? 18'sd65536 : $signed({1'b0, accel_weight_q});
  assign wc    = 18'sd65536 - w;

  logic signed [SW-1:0] mix, mixr;
  logic signed [16:0]   angle;
  assign mix  = SW'(p1_q) + SW'(p2_q) + SW'(32768);
  assign mixr = mix >>> 16;
  always_comb begin
    if (mixr > SW'(46080)) begin
      angle = 17'sd46080;
    end else if (mixr < -SW'(46080)) begin
      angle = -17'sd46080;
    end else begin
      angle = mixr[16:0];
    end
  end

  logic signed [17:0] band, angle18;
  assign band    = $signed({2'b0, dead_band_q});
  assign angle18 = 18'(angle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!calib_done_q) begin
            if ((in_gx != in_gy) && (cnt_inc >= target)) begin
              state_d = S_DIV;
            end else begin
              state_d = S_EMIT;
            end
          end else begin
            state_d = S_CORD;
          end
        end
      end
      S_DIV: begin
        if (dcnt_q == DCW'(RSW - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_CORD: begin
        if (it_q == ITER_LAST) begin
          state_d = S_GYRO;
        end
      end
      S_GYRO: state_d = S_MIX;
      S_MIX:  state_d = S_FIN;
      S_FIN:  state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      calib_count_q  <= 10'd200;
      accel_weight_q <= 17'd52429;
      gyro_gain_q    <= 16'd5866;
      dead_band_q    <= 16'd256;
      calib_done_q   <= 1'b0;
      acc_cnt_q      <= '0;
      rate_sum_q     <= '0;
      rate_off_q     <= '0;
      filt_q         <= '0;
      ph1_q          <= '0;
      ph2_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CALIB_COUNT:  calib_count_q  <= cfg_data_i[9:0];
          CFG_ACCEL_WEIGHT: accel_weight_q <= cfg_data_i;
          CFG_GYRO_GAIN:    gyro_gain_q    <= cfg_data_i[15:0];
          CFG_DEAD_BAND:    dead_band_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_fire && !calib_done_q && (in_gx != in_gy)) begin
        acc_cnt_q  <= cnt_inc;
        rate_sum_q <= sum_inc;
      end
      if (state_q == S_DIV && dcnt_q == DCW'(RSW - 1)) begin
        calib_done_q <= 1'b1;
        rate_off_q   <= neg_q ? -SB'({dvd_q[RSW-2:0], take}) : SB'({dvd_q[RSW-2:0], take});
      end
      if (state_q == S_FIN) begin
        filt_q <= angle;
        if (angle18 > band) begin
          ph1_q <= ph1_q - 3'd1;
          ph2_q <= ph2_q + 3'd1;
        end else if (angle18 < -band) begin
          ph1_q <= ph1_q + 3'd1;
          ph2_q <= ph2_q - 3'd1;
        end
      end
      if (state_q == S_EMIT && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gy_q      <= in_gy;
      cx_q      <= sx0;
      cy_q      <= sy0;
      cz_q      <= sz0;
      zero_q    <= (in_ax == 0) && (in_az == 0);
      it_q      <= '0;
      dvd_q     <= sum_abs;
      neg_q     <= sum_inc[RSW-1];
      rem_q     <= '0;
      dcnt_q    <= '0;
      res_cal_q <= 1'b1;
      res_q     <= {4'd0, 4'd0, ACT_CAL, 17'd0};
    end
    if (state_q == S_DIV) begin
      dvd_q  <= {dvd_q[RSW-2:0], take};
      rem_q  <= take ? (trial - {1'b0, acc_cnt_q}) : trial;
      dcnt_q <= dcnt_q + DCW'(1);
    end
    if (state_q == S_CORD) begin
      it_q <= it_q + 5'd1;
      if (cy_q >= 0) begin
        cx_q <= cx_q + cdx;
        cy_q <= cy_q - cdy;
        cz_q <= cz_q + catan;
      end else begin
        cx_q <= cx_q - cdx;
        cy_q <= cy_q + cdy;
        cz_q <= cz_q - catan;
      end
    end
    if (state_q == S_GYRO) begin
      acc_q   <= cord_res;
      gprod_q <= gprod;
    end
    if (state_q == S_MIX) begin
      p1_q <= 35'(w) * 35'(acc_q);
      p2_q <= (LW + 18)'(wc) * (LW + 18)'(ls);
    end
    if (state_q == S_FIN) begin
      res_cal_q <= 1'b0;
      if (angle18 > band) begin
        res_q <= {coil_of(ph2_q + 3'd1), coil_of(ph1_q - 3'd1), ACT_POS, angle};
      end else if (angle18 < -band) begin
        res_q <= {coil_of(ph2_q - 3'd1), coil_of(ph1_q + 3'd1), ACT_NEG, angle};
      end else begin
        res_q <= {COIL_HOLD, COIL_HOLD, ACT_HOLD, angle};
      end
    end
    if (state_q == S_EMIT && (!out_valid_q || m_axis_tready_i)) begin
      out_cal_q <= res_cal_q;
      out_q     <= res_q;
    end
  end

endmodule
